// ----- hdl/qsu16_pkg.sv -----
// ----------------------------------------------------------------------------
// qsu16_pkg
// Shared types, character codes and helpers of the quoted string decoder.
// ----------------------------------------------------------------------------
package qsu16_pkg;

    // Parser phase, one-hot.
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_BODY  = 5'b00010,
        PH_ESC   = 5'b00100,
        PH_UOPEN = 5'b01000,
        PH_HEX   = 5'b10000
    } t_phase;

    // Result kinds.
    localparam logic [1:0] KIND_UNIT = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_OPEN  = 3'd1;
    localparam logic [2:0] ERR_UNTERM   = 3'd2;
    localparam logic [2:0] ERR_ESCAPE   = 3'd3;
    localparam logic [2:0] ERR_HEX      = 3'd4;
    localparam logic [2:0] ERR_CODEPT   = 3'd5;
    localparam logic [2:0] ERR_OVERFLOW = 3'd6;
    localparam logic [2:0] ERR_EMPTY    = 3'd7;

    // Source characters of interest.
    localparam logic [15:0] CH_NUL    = 16'h0000;
    localparam logic [15:0] CH_TAB    = 16'h0009;
    localparam logic [15:0] CH_LF     = 16'h000A;
    localparam logic [15:0] CH_CR     = 16'h000D;
    localparam logic [15:0] CH_QUOTE  = 16'h0022;
    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_N      = 16'h006E;
    localparam logic [15:0] CH_T      = 16'h0074;
    localparam logic [15:0] CH_U      = 16'h0075;
    localparam logic [15:0] CH_LBRACE = 16'h007B;
    localparam logic [15:0] CH_RBRACE = 16'h007D;

    // Code point limits.
    localparam logic [27:0] CP_MAX       = 28'h010FFFF;
    localparam logic [27:0] CP_SURR_LO   = 28'h000D800;
    localparam logic [27:0] CP_SURR_HI   = 28'h000DFFF;
    localparam logic [27:0] CP_PLANE1    = 28'h0010000;
    localparam logic [15:0] HIGH_SURR    = 16'hD800;
    localparam logic [15:0] LOW_SURR     = 16'hDC00;
    localparam logic [15:0] CASE_BIT     = 16'h0020;

    localparam int unsigned HEX_MAX_DIGITS = 7;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] unit;
        logic [2:0]  error_code;
        logic [11:0] unit_count;
        logic        last;
    } t_result;

    // Hex digit decode: bit 4 set when the unit is a hex digit.
    function automatic logic [4:0] hex_decode(input logic [15:0] c);
        logic [15:0] lc;
        lc = c | CASE_BIT;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            hex_decode = {1'b1, c[3:0]};
        end else if (lc >= 16'h0061 && lc <= 16'h0066) begin
            hex_decode = {1'b1, 4'(lc[3:0] + 4'd9)};
        end else begin
            hex_decode = 5'd0;
        end
    endfunction

endpackage

// ----- hdl/quoted_string_unescape_utf16.sv -----
// ----------------------------------------------------------------------------
// quoted_string_unescape_utf16
// Decodes a quoted, escaped string literal into a stream of UTF-16 units.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream (s_axis_*) carries one UTF-16 source unit per item in
// tdata, with tuser set on the first unit of a new literal, which must be a
// double quote. The master stream (m_axis_*) carries the results: tuser holds
// the kind (decoded unit, literal done, literal failed), tdata the decoded
// unit, error code and running unit count, and tlast marks the final result
// caused by one source item. A code point above the basic plane leaves as a
// surrogate pair, so one source item can cause two result items.
// Each accepted item is decoded in the cycle it is accepted; its first result
// is shown on the master side in the next cycle. A two-entry result register
// sits between the sides: a new item is taken whenever that register is empty
// or its last entry leaves in the same cycle, so while results are taken at
// once one item per cycle is sustained; an item that produces a pair holds
// the input until the first half of the pair has left. When the receiver
// stalls, results wait in the register and the input stops as soon as a
// result is waiting unread. The capacity register is written through the
// cfg channel, which is always ready; the user must write it only while the
// block is idle, which the block itself does not enforce. Reset empties the
// result register, idles the parser and loads a capacity of 256.
// ----------------------------------------------------------------------------
module quoted_string_unescape_utf16
    import qsu16_pkg::*;
#(
    parameter int unsigned MAX_CAPACITY = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Capacity register write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data,
    // Source units.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [15:0] code_unit
    input  logic [0:0]  s_axis_tuser,  // [0] first
    // Results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [15:0] unit, [18:16] error_code,
                                       // [30:19] unit_count, [31] zero
    output logic [1:0]  m_axis_tuser,  // [1:0] kind
    output logic        m_axis_tlast
);

    // Effective capacity never exceeds what the 13-bit register can hold.
    localparam logic [12:0] CAP_CLIP =
        (MAX_CAPACITY > 8191) ? 13'd8191 : 13'(MAX_CAPACITY);

    // Configuration and parser state.
    logic [12:0] r_capacity;
    t_phase      r_phase,  n_phase;
    logic [27:0] r_acc,    n_acc;
    logic [2:0]  r_digits, n_digits;
    logic [12:0] r_units,  n_units;

    // Two-entry result register.
    t_result     r_res0, r_res1;
    logic [1:0]  r_cnt;

    // Decode of the current item.
    logic [15:0] c;
    logic        first;
    logic        accept;
    logic        drain;
    logic [4:0]  hex;
    logic [12:0] eff_cap;
    logic [12:0] base_units;
    logic        do_push;
    logic [27:0] push_cp;
    logic [19:0] pair_v;
    logic        act_fail;
    logic [2:0]  fail_err;
    logic        act_done;
    logic [1:0]  new_cnt;
    t_result     new_res0, new_res1;

    assign c       = s_axis_tdata;
    assign first   = s_axis_tuser[0];
    assign hex     = hex_decode(c);
    assign eff_cap = (r_capacity > CAP_CLIP) ? CAP_CLIP : r_capacity;
    assign pair_v  = 20'(push_cp - CP_PLANE1);

    assign o_cfg_ready   = 1'b1;
    assign drain         = m_axis_tvalid && m_axis_tready;
    // Take a new item when the result register is empty or about to be.
    assign s_axis_tready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Parser step: first decide the action, then size up any code point.
    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_digits   = r_digits;
        n_units    = r_units;
        do_push    = 1'b0;
        push_cp    = '0;
        act_fail   = 1'b0;
        fail_err   = ERR_NONE;
        act_done   = 1'b0;
        base_units = first ? 13'd0 : r_units;

        if (first) begin
            n_units  = '0;
            n_acc    = '0;
            n_digits = '0;
            if (c != CH_QUOTE) begin
                act_fail = 1'b1;
                fail_err = ERR_NO_OPEN;
            end else begin
                n_phase = PH_BODY;
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                PH_BODY: begin
                    if (c == CH_NUL || c == CH_LF || c == CH_CR) begin
                        act_fail = 1'b1;
                        fail_err = ERR_UNTERM;
                    end else if (c == CH_QUOTE) begin
                        if (r_units == '0) begin
                            act_fail = 1'b1;
                            fail_err = ERR_EMPTY;
                        end else begin
                            act_done = 1'b1;
                            n_phase  = PH_IDLE;
                        end
                    end else if (c == CH_BSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        do_push = 1'b1;
                        push_cp = 28'(c);
                    end
                end
                PH_ESC: begin
                    if (c == CH_QUOTE || c == CH_BSLASH) begin
                        do_push = 1'b1;
                        push_cp = 28'(c);
                    end else if (c == CH_N) begin
                        do_push = 1'b1;
                        push_cp = 28'(CH_LF);
                    end else if (c == CH_T) begin
                        do_push = 1'b1;
                        push_cp = 28'(CH_TAB);
                    end else if (c == CH_U) begin
                        n_phase = PH_UOPEN;
                    end else begin
                        act_fail = 1'b1;
                        fail_err = ERR_ESCAPE;
                    end
                end
                PH_UOPEN: begin
                    if (c != CH_LBRACE) begin
                        act_fail = 1'b1;
                        fail_err = ERR_ESCAPE;
                    end else begin
                        n_acc    = '0;
                        n_digits = '0;
                        n_phase  = PH_HEX;
                    end
                end
                PH_HEX: begin
                    if (hex[4] && (r_digits < 3'(HEX_MAX_DIGITS))) begin
                        n_acc    = {r_acc[23:0], hex[3:0]};
                        n_digits = r_digits + 3'd1;
                    end else if (c == CH_RBRACE && r_digits != '0) begin
                        do_push = 1'b1;
                        push_cp = r_acc;
                    end else begin
                        act_fail = 1'b1;
                        fail_err = ERR_HEX;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        // Code point output: range check, then room check against capacity.
        new_cnt  = 2'd0;
        new_res0 = '0;
        new_res1 = '0;
        if (do_push) begin
            if (push_cp == '0 || push_cp > CP_MAX ||
                (push_cp >= CP_SURR_LO && push_cp <= CP_SURR_HI)) begin
                act_fail = 1'b1;
                fail_err = ERR_CODEPT;
            end else if (push_cp >= CP_PLANE1) begin
                if ({1'b0, base_units} + 14'd2 >= {1'b0, eff_cap}) begin
                    act_fail = 1'b1;
                    fail_err = ERR_OVERFLOW;
                end else begin
                    n_units             = base_units + 13'd2;
                    n_phase             = PH_BODY;
                    new_cnt             = 2'd2;
                    new_res0.kind       = KIND_UNIT;
                    new_res0.unit       = HIGH_SURR + 16'(pair_v[19:10]);
                    new_res0.unit_count = 12'(base_units + 13'd1);
                    new_res1.kind       = KIND_UNIT;
                    new_res1.unit       = LOW_SURR + 16'(pair_v[9:0]);
                    new_res1.unit_count = 12'(base_units + 13'd2);
                    new_res1.last       = 1'b1;
                end
            end else begin
                if ({1'b0, base_units} + 14'd1 >= {1'b0, eff_cap}) begin
                    act_fail = 1'b1;
                    fail_err = ERR_OVERFLOW;
                end else begin
                    n_units             = base_units + 13'd1;
                    n_phase             = PH_BODY;
                    new_cnt             = 2'd1;
                    new_res0.kind       = KIND_UNIT;
                    new_res0.unit       = push_cp[15:0];
                    new_res0.unit_count = 12'(base_units + 13'd1);
                    new_res0.last       = 1'b1;
                end
            end
        end

        if (act_fail) begin
            // A failure reports the units produced before the error.
            n_phase             = PH_IDLE;
            n_units             = base_units;
            new_cnt             = 2'd1;
            new_res0            = '0;
            new_res0.kind       = KIND_FAIL;
            new_res0.error_code = fail_err;
            new_res0.unit_count = base_units[11:0];
            new_res0.last       = 1'b1;
        end else if (act_done) begin
            new_cnt             = 2'd1;
            new_res0            = '0;
            new_res0.kind       = KIND_DONE;
            new_res0.unit_count = r_units[11:0];
            new_res0.last       = 1'b1;
        end
    end

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 13'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_capacity <= i_cfg_data;
        end
    end

    // Parser state advances only on an accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_acc    <= '0;
            r_digits <= '0;
            r_units  <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_digits <= n_digits;
            r_units  <= n_units;
        end
    end

    // Result register fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (accept) begin
            r_cnt <= new_cnt;
        end else if (drain) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Result register payload; the second entry moves up as the first leaves.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res0 <= new_res0;
            r_res1 <= new_res1;
        end else if (drain && r_cnt == 2'd2) begin
            r_res0 <= r_res1;
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {1'b0, r_res0.unit_count, r_res0.error_code, r_res0.unit};
    assign m_axis_tuser  = r_res0.kind;
    assign m_axis_tlast  = r_res0.last;

    // The register never holds more than a pair.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result register over-full");

    // A full register must block the input.
    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !s_axis_tready)
        else $error("item accepted while a pair is pending");

    // A shown result without tlast is the high half of a pair still queued.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |->
            (r_cnt == 2'd2 && r_res0.kind == KIND_UNIT && r_res1.last))
        else $error("unterminated result group");

    // A failure result ends the literal.
    a_fail_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && new_cnt != 2'd0 && new_res0.kind == KIND_FAIL) |=>
            (r_phase == PH_IDLE))
        else $error("parser still active after a failure");

    // A failure always carries an error code and no unit.
    a_fail_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_FAIL) |->
            (r_res0.error_code != ERR_NONE && r_res0.unit == 16'd0))
        else $error("failure result without an error code");

endmodule

// ----- dv/qsu16_decode_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qsu16_decode_check
// Watches the source, result and capacity channels of the string decoder,
// predicts the decoded units and verdicts of each literal, and compares every
// result item with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module qsu16_decode_check
    import qsu16_pkg::*;
#(
    parameter int unsigned MAX_CAPACITY = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [12:0] i_cfg_data,
    input  logic        i_src_valid,
    input  logic        i_src_ready,
    input  logic [15:0] i_src_unit,
    input  logic        i_src_first,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [31:0] i_res_data,
    input  logic [1:0]  i_res_kind,
    input  logic        i_res_last,
    output int          o_mismatches,
    output int          o_outstanding
);

    // Parser state as the block should hold it.
    t_phase      ph;
    logic [27:0] cp_acc;
    logic [2:0]  digit_cnt;
    logic [11:0] units_out;
    logic [12:0] capacity;

    // Results of the item being decoded, then the predicted result stream.
    t_result     step_res [2];
    int          step_n;
    t_result     decoded_q [$];

    int          err_cnt = 0;
    int          pending = 0;

    assign o_mismatches  = err_cnt;
    assign o_outstanding = pending;

    function automatic int hex_digit(input logic [15:0] c);
        if (c >= 16'h0030 && c <= 16'h0039) return int'(c - 16'h0030);
        if (c >= 16'h0041 && c <= 16'h0046) return int'(c - 16'h0041) + 10;
        if (c >= 16'h0061 && c <= 16'h0066) return int'(c - 16'h0061) + 10;
        return -1;
    endfunction

    task automatic emit(input logic [1:0] k, input logic [15:0] u, input logic [2:0] e);
        step_res[step_n] = '{kind: k, unit: u, error_code: e, unit_count: units_out,
                             last: 1'b0};
        step_n++;
    endtask

    task automatic abort_literal(input logic [2:0] e);
        emit(KIND_FAIL, 16'h0000, e);
        ph = PH_IDLE;
    endtask

    // A code point leaves as one unit or as a surrogate pair; a pair that
    // does not fit below the capacity is refused as a whole.
    task automatic emit_code_point(input logic [27:0] cp);
        int          lim;
        logic [27:0] v;
        lim = (capacity > MAX_CAPACITY) ? int'(MAX_CAPACITY) : int'(capacity);
        v   = cp - CP_PLANE1;
        if (cp == 28'h0 || cp > CP_MAX || (cp >= CP_SURR_LO && cp <= CP_SURR_HI)) begin
            abort_literal(ERR_CODEPT);
        end else if (cp >= CP_PLANE1) begin
            if (int'(units_out) + 2 >= lim) begin
                abort_literal(ERR_OVERFLOW);
            end else begin
                units_out++;
                emit(KIND_UNIT, HIGH_SURR + {6'h0, v[19:10]}, ERR_NONE);
                units_out++;
                emit(KIND_UNIT, LOW_SURR + {6'h0, v[9:0]}, ERR_NONE);
                ph = PH_BODY;
            end
        end else if (int'(units_out) + 1 >= lim) begin
            abort_literal(ERR_OVERFLOW);
        end else begin
            units_out++;
            emit(KIND_UNIT, cp[15:0], ERR_NONE);
            ph = PH_BODY;
        end
    endtask

    task automatic decode_unit(input logic [15:0] c, input logic first);
        int h;
        step_n = 0;
        h      = hex_digit(c);
        if (first) begin
            units_out = '0;
            cp_acc    = '0;
            digit_cnt = '0;
            if (c != CH_QUOTE) abort_literal(ERR_NO_OPEN);
            else ph = PH_BODY;
        end else begin
            case (ph)
                PH_BODY: begin
                    if (c == CH_NUL || c == CH_LF || c == CH_CR) begin
                        abort_literal(ERR_UNTERM);
                    end else if (c == CH_QUOTE) begin
                        if (units_out == 12'h0) begin
                            abort_literal(ERR_EMPTY);
                        end else begin
                            emit(KIND_DONE, 16'h0000, ERR_NONE);
                            ph = PH_IDLE;
                        end
                    end else if (c == CH_BSLASH) begin
                        ph = PH_ESC;
                    end else begin
                        emit_code_point({12'h0, c});
                    end
                end
                PH_ESC: begin
                    if (c == CH_QUOTE || c == CH_BSLASH) emit_code_point({12'h0, c});
                    else if (c == CH_N) emit_code_point({12'h0, CH_LF});
                    else if (c == CH_T) emit_code_point({12'h0, CH_TAB});
                    else if (c == CH_U) ph = PH_UOPEN;
                    else abort_literal(ERR_ESCAPE);
                end
                PH_UOPEN: begin
                    if (c != CH_LBRACE) begin
                        abort_literal(ERR_ESCAPE);
                    end else begin
                        cp_acc    = '0;
                        digit_cnt = '0;
                        ph        = PH_HEX;
                    end
                end
                PH_HEX: begin
                    if (h >= 0 && digit_cnt < HEX_MAX_DIGITS) begin
                        cp_acc = {cp_acc[23:0], 4'(h)};
                        digit_cnt++;
                    end else if (c == CH_RBRACE && digit_cnt != 3'd0) begin
                        emit_code_point(cp_acc);
                    end else begin
                        abort_literal(ERR_HEX);
                    end
                end
                default: ph = PH_IDLE;
            endcase
        end
        if (step_n > 0) step_res[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++) decoded_q.push_back(step_res[i]);
    endtask

    task automatic check_result();
        t_result want;
        logic    ok;
        if (decoded_q.size() == 0) begin
            if (err_cnt < 10)
                $display("%0t: result with nothing predicted: kind %0d data %h last %0b",
                         $realtime, i_res_kind, i_res_data, i_res_last);
            err_cnt++;
        end else begin
            want = decoded_q.pop_front();
            ok = (i_res_kind === want.kind) && (i_res_data[15:0] === want.unit) &&
                 (i_res_data[18:16] === want.error_code) &&
                 (i_res_data[30:19] === want.unit_count) &&
                 (i_res_data[31] === 1'b0) && (i_res_last === want.last);
            if (!ok) begin
                if (err_cnt < 10)
                    $display({"%0t: mismatch: expected kind %0d unit %h err %0d count %0d",
                              " pad 0 last %0b, got kind %0d unit %h err %0d count %0d",
                              " pad %0b last %0b"},
                             $realtime, want.kind, want.unit, want.error_code,
                             want.unit_count, want.last, i_res_kind, i_res_data[15:0],
                             i_res_data[18:16], i_res_data[30:19], i_res_data[31],
                             i_res_last);
                err_cnt++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ph        = PH_IDLE;
            cp_acc    = '0;
            digit_cnt = '0;
            units_out = '0;
            capacity  = 13'd256;
            decoded_q.delete();
        end else begin
            // A result at this edge can only stem from an earlier item, so it
            // is checked before the item taken at the same edge is decoded.
            if (i_res_valid && i_res_ready) check_result();
            if (i_cfg_valid && i_cfg_ready) capacity = i_cfg_data;
            if (i_src_valid && i_src_ready) decode_unit(i_src_unit, i_src_first);
        end
        pending <= decoded_q.size();
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the quoted string decoder. Feeds directed and
// random literals through the source stream under several capacity settings,
// with bursty input and a stalling receiver; the decode checker beside the
// block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_top;
    import qsu16_pkg::*;

    localparam int unsigned MAX_CAP = 4096;
    // Cycles without any accepted item before the run is declared hung. The
    // slowest correct stretches are a gap between sender bursts and a receiver
    // stall, both much shorter, so this leaves a wide margin.
    localparam int STALL_LIMIT = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [12:0] cfg_data;
    logic        src_valid;
    logic        src_ready;
    logic [15:0] src_data;
    logic [0:0]  src_first;
    logic        res_valid;
    logic        res_ready;
    logic [31:0] res_data;
    logic [1:0]  res_kind;
    logic        res_last;

    int          mismatches;
    int          outstanding;
    int          burst_left;
    int          items_sent;

    // Units of the literal being assembled: bit 16 is the first flag.
    logic [16:0] literal_units [$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    quoted_string_unescape_utf16 #(
        .MAX_CAPACITY(MAX_CAP)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (src_valid),
        .s_axis_tready (src_ready),
        .s_axis_tdata  (src_data),
        .s_axis_tuser  (src_first),
        .m_axis_tvalid (res_valid),
        .m_axis_tready (res_ready),
        .m_axis_tdata  (res_data),
        .m_axis_tuser  (res_kind),
        .m_axis_tlast  (res_last)
    );

    qsu16_decode_check #(
        .MAX_CAPACITY(MAX_CAP)
    ) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_src_valid   (src_valid),
        .i_src_ready   (src_ready),
        .i_src_unit    (src_data),
        .i_src_first   (src_first[0]),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_res_data    (res_data),
        .i_res_kind    (res_kind),
        .i_res_last    (res_last),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // The receiver replays a 16-slot ready mask and picks a new one at random
    // intervals: always ready, random, sparse, or one stall slot per period.
    // Every mask has at least one ready slot.
    initial begin
        logic [15:0] mask;
        int          left;
        res_ready = 1'b0;
        mask      = 16'hFFFF;
        left      = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                case ($urandom_range(0, 3))
                    0: mask = 16'hFFFF;
                    1: mask = 16'($urandom) | 16'h0001;
                    2: mask = (16'($urandom) & 16'($urandom)) | 16'h0001;
                    default: mask = ~(16'h0001 << $urandom_range(0, 15));
                endcase
                left = $urandom_range(32, 256);
            end
            res_ready <= mask[left % 16];
            left--;
        end
    end

    // The watchdog ends the run when no channel has moved an item for too
    // long, which is what a hung block looks like from outside.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((src_valid && src_ready) || (res_valid && res_ready) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Drives one source item and returns at the falling edge after it was
    // taken. The sender works in bursts; between bursts valid drops for a
    // random gap, and valid is only lowered when a gap actually follows.
    task automatic send_item(input logic [15:0] code, input logic first);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
            if (gap > 0) begin
                src_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        src_valid <= 1'b1;
        src_data  <= code;
        src_first <= first;
        do @(posedge i_clk); while (!src_ready);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic queue_unit(input logic [15:0] code, input logic first);
        literal_units.push_back({first, code});
    endtask

    task automatic send_literal();
        foreach (literal_units[i]) send_item(literal_units[i][15:0], literal_units[i][16]);
        literal_units.delete();
    endtask

    // The capacity is only changed with the block idle: every predicted result
    // has arrived, and an added wait covers items that produce no result.
    task automatic write_capacity(input logic [12:0] value);
        src_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid  <= 1'b0;
        burst_left = 0;
    endtask

    function automatic logic is_special(input logic [15:0] c);
        return c == CH_NUL || c == CH_LF || c == CH_CR || c == CH_QUOTE ||
               c == CH_BSLASH || (c >= 16'hD800 && c <= 16'hDFFF);
    endfunction

    // A body unit: mostly printable ASCII or any non-special unit of the
    // whole 16-bit range, now and then a bare surrogate, which is an error.
    function automatic logic [15:0] plain_unit();
        logic [15:0] c;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            c = 16'($urandom_range(16'h0020, 16'h007E));
            if (c == CH_QUOTE || c == CH_BSLASH) c = 16'h0041;
        end else if (r < 97) begin
            c = 16'($urandom);
            if (is_special(c)) c = c ^ 16'h8000;
        end else begin
            c = 16'($urandom_range(16'hD800, 16'hDFFF));
        end
        return c;
    endfunction

    // Hex digit character, letters in either case.
    function automatic logic [15:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 16'h0030 + 16'(nib);
        return (($urandom_range(0, 1) != 0) ? 16'h0061 : 16'h0041) + 16'(nib - 4'd10);
    endfunction

    function automatic int digits_for(input logic [27:0] cp);
        int n;
        n = 1;
        while (n < 7 && (cp >> (4 * n)) != 28'h0) n++;
        return n;
    endfunction

    task automatic queue_hex_open();
        queue_unit(CH_BSLASH, 1'b0);
        queue_unit(CH_U, 1'b0);
        queue_unit(CH_LBRACE, 1'b0);
    endtask

    // A complete braced hex escape with 1 to 7 digits, leading zeros allowed.
    task automatic queue_hex(input logic [27:0] cp, input int digits);
        queue_hex_open();
        for (int i = digits - 1; i >= 0; i--) queue_unit(hex_char(cp[i * 4 +: 4]), 1'b0);
        queue_unit(CH_RBRACE, 1'b0);
    endtask

    function automatic logic [15:0] terminator();
        case ($urandom_range(0, 2))
            0: return CH_NUL;
            1: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // One malformed construct; most of them end the literal with an error.
    task automatic queue_broken();
        logic [27:0] cp;
        case ($urandom_range(0, 8))
            0: queue_unit(terminator(), 1'b0);
            1: begin
                queue_unit(CH_BSLASH, 1'b0);
                queue_unit(terminator(), 1'b0);
            end
            2: begin
                queue_unit(CH_BSLASH, 1'b0);
                queue_unit(plain_unit(), 1'b0);
            end
            3: begin
                queue_unit(CH_BSLASH, 1'b0);
                queue_unit(CH_U, 1'b0);
                queue_unit(plain_unit(), 1'b0);
            end
            4: begin
                queue_hex_open();
                queue_unit(CH_RBRACE, 1'b0);
            end
            5: begin
                queue_hex_open();
                repeat (8) queue_unit(hex_char(4'($urandom)), 1'b0);
            end
            6: begin
                queue_hex_open();
                repeat ($urandom_range(0, 7)) queue_unit(hex_char(4'($urandom)), 1'b0);
                queue_unit(plain_unit(), 1'b0);
            end
            7: begin
                cp = 28'($urandom_range(28'h0110000, 28'hFFFFFFF));
                queue_hex(cp, $urandom_range(digits_for(cp), 7));
            end
            default: begin
                cp = ($urandom_range(0, 2) == 0) ? 28'h0
                                                 : 28'($urandom_range(28'hD800, 28'hDFFF));
                queue_hex(cp, $urandom_range(digits_for(cp), 7));
            end
        endcase
    endtask

    // A random literal of up to max_tokens tokens. Most are well formed and
    // closed; some are cut off so that the next literal restarts the parser,
    // and some end in a stray unit in place of the close.
    task automatic queue_literal(input int max_tokens);
        logic [27:0] cp;
        int          r;
        queue_unit(CH_QUOTE, 1'b1);
        repeat ($urandom_range(0, max_tokens)) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                queue_unit(plain_unit(), 1'b0);
            end else if (r < 60) begin
                queue_unit(CH_BSLASH, 1'b0);
                case ($urandom_range(0, 3))
                    0: queue_unit(CH_QUOTE, 1'b0);
                    1: queue_unit(CH_BSLASH, 1'b0);
                    2: queue_unit(CH_N, 1'b0);
                    default: queue_unit(CH_T, 1'b0);
                endcase
            end else if (r < 74) begin
                cp = 28'($urandom_range(1, 16'hFFFF));
                if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) cp = cp ^ 28'h8000;
                queue_hex(cp, $urandom_range(digits_for(cp), 7));
            end else if (r < 86) begin
                cp = 28'($urandom_range(28'h10000, 28'h10FFFF));
                queue_hex(cp, $urandom_range(digits_for(cp), 7));
            end else if (r < 89) begin
                queue_broken();
            end else begin
                queue_unit(plain_unit(), 1'b0);
            end
        end
        r = $urandom_range(0, 19);
        if (r < 18) queue_unit(CH_QUOTE, 1'b0);
        else if (r == 18) queue_unit(16'($urandom), 1'b0);
    endtask

    // Random literals until about budget items have been sent, with some
    // noise between them: stray units while idle and bad opening units.
    task automatic run_random(input int budget, input int max_tokens);
        int stop;
        stop = items_sent + budget;
        while (items_sent < stop) begin
            if ($urandom_range(0, 9) == 0) queue_unit(16'($urandom), 1'($urandom));
            queue_literal(max_tokens);
            send_literal();
        end
    endtask

    // A literal of plain ASCII units that avoid the quote and the backslash,
    // ending either in a supplementary escape or in the closing quote.
    task automatic long_literal(input int plain_n, input logic end_with_pair);
        queue_unit(CH_QUOTE, 1'b1);
        repeat (plain_n) queue_unit(16'($urandom_range(16'h0023, 16'h005B)), 1'b0);
        if (end_with_pair) queue_hex(28'h1F600, 5);
        else queue_unit(CH_QUOTE, 1'b0);
        send_literal();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        src_valid  = 1'b0;
        src_data   = '0;
        src_first  = '0;
        burst_left = 0;
        items_sent = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed literals under the reset capacity of 256.
        // A unit with first clear while idle is ignored; a first unit that is
        // not a quote fails at once.
        queue_unit(16'h0041, 1'b0);
        queue_unit(CH_NUL, 1'b1);
        // Largest plain unit, every simple escape and the largest code point.
        queue_unit(CH_QUOTE, 1'b1);
        queue_unit(16'hFFFF, 1'b0);
        queue_unit(CH_BSLASH, 1'b0);
        queue_unit(CH_N, 1'b0);
        queue_unit(CH_BSLASH, 1'b0);
        queue_unit(CH_T, 1'b0);
        queue_unit(CH_BSLASH, 1'b0);
        queue_unit(CH_QUOTE, 1'b0);
        queue_unit(CH_BSLASH, 1'b0);
        queue_unit(CH_BSLASH, 1'b0);
        queue_hex(28'h10FFFF, 6);
        queue_unit(CH_QUOTE, 1'b0);
        // Empty literal.
        queue_unit(CH_QUOTE, 1'b1);
        queue_unit(CH_QUOTE, 1'b0);
        // Smallest plain unit, then a seven-digit escape and the closing quote.
        queue_unit(CH_QUOTE, 1'b1);
        queue_unit(16'h0001, 1'b0);
        queue_hex(28'h0000041, 7);
        queue_unit(CH_QUOTE, 1'b0);
        // Code points above the range, zero, and a surrogate.
        queue_unit(CH_QUOTE, 1'b1);
        queue_hex(28'h110000, 6);
        queue_unit(CH_QUOTE, 1'b1);
        queue_hex(28'h0, 1);
        queue_unit(CH_QUOTE, 1'b1);
        queue_hex(28'hDFFF, 4);
        // A bare surrogate unit in the body.
        queue_unit(CH_QUOTE, 1'b1);
        queue_unit(16'hD800, 1'b0);
        // NUL in the body, and a line feed in place of an escape letter.
        queue_unit(CH_QUOTE, 1'b1);
        queue_unit(CH_NUL, 1'b0);
        queue_unit(CH_QUOTE, 1'b1);
        queue_unit(CH_BSLASH, 1'b0);
        queue_unit(CH_LF, 1'b0);
        // Unknown escape letter and a hex escape without its brace.
        queue_unit(CH_QUOTE, 1'b1);
        queue_unit(CH_BSLASH, 1'b0);
        queue_unit(16'h0078, 1'b0);
        queue_unit(CH_QUOTE, 1'b1);
        queue_unit(CH_BSLASH, 1'b0);
        queue_unit(CH_U, 1'b0);
        queue_unit(16'h0061, 1'b0);
        // Braces with no digits, an eighth digit, and a non-hex unit.
        queue_unit(CH_QUOTE, 1'b1);
        queue_hex_open();
        queue_unit(CH_RBRACE, 1'b0);
        queue_unit(CH_QUOTE, 1'b1);
        queue_hex_open();
        for (int i = 1; i <= 8; i++) queue_unit(hex_char(4'(i)), 1'b0);
        queue_unit(CH_QUOTE, 1'b1);
        queue_hex_open();
        queue_unit(16'h0031, 1'b0);
        queue_unit(16'h0067, 1'b0);
        // A literal abandoned halfway by a new first unit.
        queue_unit(CH_QUOTE, 1'b1);
        queue_unit(16'h0061, 1'b0);
        queue_unit(CH_QUOTE, 1'b1);
        queue_unit(16'h0063, 1'b0);
        queue_unit(CH_QUOTE, 1'b0);
        send_literal();

        run_random(150, 12);

        // Values above the maximum act as the maximum.
        write_capacity(13'h1FFF);
        run_random(100, 12);

        // Capacities of zero and one leave no room for any unit.
        write_capacity(13'd0);
        run_random(40, 4);
        write_capacity(13'd1);
        run_random(40, 4);
        write_capacity(13'd2);
        run_random(60, 4);

        // With a capacity of three, one unit fits but a following pair is
        // refused whole.
        write_capacity(13'd3);
        queue_unit(CH_QUOTE, 1'b1);
        queue_unit(16'h0061, 1'b0);
        queue_hex(28'h1F600, 5);
        send_literal();
        run_random(50, 4);

        write_capacity(13'($urandom_range(4, 24)));
        run_random(120, 8);
        write_capacity(13'($urandom_range(25, 300)));
        run_random(120, 16);

        // At a capacity of 64: a pair refused just short of the end, then a
        // literal that reaches the largest unit count this capacity allows.
        write_capacity(13'd64);
        long_literal(62, 1'b1);
        long_literal(63, 1'b0);
        run_random(80, 12);

        // Drain every predicted result, then keep waiting so that anything
        // the block might still emit on its own is seen.
        src_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
